// ===== design/qmr_pkg.sv =====
// shared types and the hamilton product term tables for the quaternion unit
package qmr_pkg;

  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_ROTATE  = 1'b1
  } op_t;

  // depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // component order is w, x, y, z; each result component sums four terms
  // a[HAM_A_IDX] * b[HAM_B_IDX], subtracted where HAM_NEG is set
  localparam logic [1:0] HAM_A_IDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };

  localparam logic [1:0] HAM_B_IDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };

  localparam logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

endpackage

// ===== design/qmr_front.sv =====
// front end: takes requests, classifies the op and registers the queue entry
module qmr_front import qmr_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [3:0][WORD_BITS-1:0]   in_a,
  input  logic [3:0][WORD_BITS-1:0]   in_b,
  output logic                        q_push,
  input  logic                        q_full,
  output logic [8*WORD_BITS:0]        q_entry
);

  logic                      fv_r;
  logic                      load;
  op_t                       op;
  logic [3:0][WORD_BITS-1:0] b_cls;
  logic [8*WORD_BITS:0]      entry_r;

  assign q_push   = fv_r && !q_full;
  assign load     = !fv_r || q_push;
  assign in_stall = !load;
  assign q_entry  = entry_r;

  // rotation uses b as a pure vector, so its scalar part is cleared here
  always_comb begin
    op    = op_t'(in_op);
    b_cls = in_b;
    if (op == OP_ROTATE) begin
      b_cls[0] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (load) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      entry_r <= {in_op, in_a, b_cls};
    end
  end

endmodule

// ===== design/qmr_fifo.sv =====
// small register queue that decouples the front end from the back end
module qmr_fifo import qmr_pkg::*; #(
  parameter int DW = 257
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] rd_data
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0]   mem_r [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign full      = (cnt_r == CNTW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/qmr_ham.sv =====
// four-stage pipelined hamilton product with round and saturate
module qmr_ham import qmr_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [3:0][WORD_BITS:0]   a_i,
  input  logic [3:0][WORD_BITS:0]   b_i,
  output logic [3:0][WORD_BITS-1:0] r_o,
  output logic [3:0]                sat_o
);

  localparam int OW  = WORD_BITS + 1;
  localparam int H   = OW / 2;
  localparam int HW  = OW - H;
  localparam int PLW = OW + H + 1;
  localparam int PHW = OW + HW;
  localparam int PW  = 2 * OW;
  localparam int SW  = PW + 2;

  localparam logic signed [SW-1:0]   HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [WORD_BITS-1:0]   MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0]   MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic signed [PLW-1:0] pl_r     [4][4];
  logic signed [PHW-1:0] ph_r     [4][4];
  logic signed [PW-1:0]  prod_nxt [4][4];
  logic signed [PW-1:0]  prod_r   [4][4];
  logic signed [SW-1:0]  sum_nxt  [4];
  logic signed [SW-1:0]  sum_r    [4];
  logic signed [SW-1:0]  rnd      [4];
  logic signed [SW-1:0]  shf      [4];
  logic [3:0][WORD_BITS-1:0] r_nxt;
  logic [3:0]                sat_nxt;
  logic [3:0][WORD_BITS-1:0] r_r;
  logic [3:0]                sat_r;

  assign r_o   = r_r;
  assign sat_o = sat_r;

  // stage 1: split each product on b into a signed high and unsigned low half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          pl_r[c][k] <= $signed(a_i[HAM_A_IDX[c][k]])
                      * $signed({1'b0, b_i[HAM_B_IDX[c][k]][H-1:0]});
          ph_r[c][k] <= $signed(a_i[HAM_A_IDX[c][k]])
                      * $signed(b_i[HAM_B_IDX[c][k]][OW-1:H]);
        end
      end
    end
  end

  // stage 2: recombine the halves into the exact product
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_nxt[c][k] = (PW'(ph_r[c][k]) <<< H) + PW'(pl_r[c][k]);
      end
    end
  end

  // stage 3: signed sum of the four terms
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_nxt[c] = '0;
      for (int k = 0; k < 4; k++) begin
        if (HAM_NEG[c][k]) begin
          sum_nxt[c] = sum_nxt[c] - SW'(prod_r[c][k]);
        end else begin
          sum_nxt[c] = sum_nxt[c] + SW'(prod_r[c][k]);
        end
      end
    end
  end

  // stage 4: round half up, drop fraction bits, saturate to the word
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd[c] = sum_r[c] + HALF;
      shf[c] = rnd[c] >>> FRAC_BITS;
      sat_nxt[c] = !((&shf[c][SW-1:WORD_BITS-1]) || !(|shf[c][SW-1:WORD_BITS-1]));
      if (sat_nxt[c]) begin
        r_nxt[c] = rnd[c][SW-1] ? MINV : MAXV;
      end else begin
        r_nxt[c] = shf[c][WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      r_r    <= r_nxt;
      sat_r  <= sat_nxt;
    end
  end

endmodule

// ===== design/qmr_back.sv =====
// back end: two chained hamilton pipelines, result select and output register
module qmr_back import qmr_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_stall,
  input  logic [8*WORD_BITS:0]      q_entry,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0][WORD_BITS-1:0] out_r,
  output logic                      out_overflow
);

  localparam int OW = WORD_BITS + 1;
  localparam int HL = 4;

  logic                      adv;
  op_t                       q_op;
  logic [3:0][WORD_BITS-1:0] q_a;
  logic [3:0][WORD_BITS-1:0] q_b;
  logic [3:0][OW-1:0]        a1;
  logic [3:0][OW-1:0]        b1;
  logic [3:0][OW-1:0]        a2;
  logic [3:0][OW-1:0]        b2;
  logic [3:0][WORD_BITS-1:0] r1;
  logic [3:0]                sat1;
  logic [3:0][WORD_BITS-1:0] r2;
  logic [3:0]                sat2;

  logic [2*HL-1:0]           vld_r;
  op_t                       op_d_r   [HL];
  logic [3:0][WORD_BITS-1:0] a_d_r    [HL];
  op_t                       op2_d_r  [HL];
  logic [3:0][WORD_BITS-1:0] r1_d_r   [HL];
  logic [3:0]                sat1_d_r [HL];

  logic                      out_valid_r;
  logic [3:0][WORD_BITS-1:0] out_r_r;
  logic                      out_ovf_r;
  logic [3:0][WORD_BITS-1:0] res_nxt;
  logic                      ovf_nxt;

  // the whole back end moves as one pipeline behind the output register
  assign adv     = !out_valid_r || !out_stall;
  assign q_stall = !adv;

  assign q_op = op_t'(q_entry[8*WORD_BITS]);
  assign q_a  = q_entry[8*WORD_BITS-1:4*WORD_BITS];
  assign q_b  = q_entry[4*WORD_BITS-1:0];

  // first pass works on a and b (or the pure vector), second on t and conj(a)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a1[i] = {q_a[i][WORD_BITS-1], q_a[i]};
      b1[i] = {q_b[i][WORD_BITS-1], q_b[i]};
      a2[i] = {r1[i][WORD_BITS-1], r1[i]};
      if (i == 0) begin
        b2[i] = {a_d_r[HL-1][i][WORD_BITS-1], a_d_r[HL-1][i]};
      end else begin
        b2[i] = OW'(0) - {a_d_r[HL-1][i][WORD_BITS-1], a_d_r[HL-1][i]};
      end
    end
  end

  qmr_ham #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ham1 (
    .clk   (clk),
    .en    (adv),
    .a_i   (a1),
    .b_i   (b1),
    .r_o   (r1),
    .sat_o (sat1)
  );

  qmr_ham #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ham2 (
    .clk   (clk),
    .en    (adv),
    .a_i   (a2),
    .b_i   (b2),
    .r_o   (r2),
    .sat_o (sat2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[2*HL-2:0], q_valid};
      out_valid_r <= vld_r[2*HL-1];
    end
  end

  // side delay lines keep op, a and the first-pass result beside the pipelines
  always_ff @(posedge clk) begin
    if (adv) begin
      op_d_r[0]   <= q_op;
      a_d_r[0]    <= q_a;
      op2_d_r[0]  <= op_d_r[HL-1];
      r1_d_r[0]   <= r1;
      sat1_d_r[0] <= sat1;
      for (int i = 1; i < HL; i++) begin
        op_d_r[i]   <= op_d_r[i-1];
        a_d_r[i]    <= a_d_r[i-1];
        op2_d_r[i]  <= op2_d_r[i-1];
        r1_d_r[i]   <= r1_d_r[i-1];
        sat1_d_r[i] <= sat1_d_r[i-1];
      end
    end
  end

  always_comb begin
    ovf_nxt = |sat1_d_r[HL-1];
    res_nxt = r1_d_r[HL-1];
    if (op2_d_r[HL-1] == OP_ROTATE) begin
      res_nxt    = r2;
      res_nxt[0] = '0;
      ovf_nxt    = ovf_nxt || (|sat2[3:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r_r   <= res_nxt;
      out_ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_r        = out_r_r;
  assign out_overflow = out_ovf_r;

endmodule

// ===== design/quaternion_multiply_rotate.sv =====
// quaternion product and vector rotation unit, top level
// path from request acceptance to out_valid with no stalls:
//   front register, queue slot, 4 + 4 hamilton stages, output register
// throughput: one request per cycle while out_stall is low, set by the fully pipelined multipliers
// a 4-entry queue lets the front keep taking requests while the back stalls
// reset: synchronous active-low rst_n empties front, queue and pipeline valids
module quaternion_multiply_rotate import qmr_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic signed [WORD_BITS-1:0] in_a_w,
  input  logic signed [WORD_BITS-1:0] in_a_x,
  input  logic signed [WORD_BITS-1:0] in_a_y,
  input  logic signed [WORD_BITS-1:0] in_a_z,
  input  logic signed [WORD_BITS-1:0] in_b_w,
  input  logic signed [WORD_BITS-1:0] in_b_x,
  input  logic signed [WORD_BITS-1:0] in_b_y,
  input  logic signed [WORD_BITS-1:0] in_b_z,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_r_w,
  output logic signed [WORD_BITS-1:0] out_r_x,
  output logic signed [WORD_BITS-1:0] out_r_y,
  output logic signed [WORD_BITS-1:0] out_r_z,
  output logic                        out_overflow
);

  localparam int EW = 8 * WORD_BITS + 1;

  logic [3:0][WORD_BITS-1:0] in_a;
  logic [3:0][WORD_BITS-1:0] in_b;
  logic                      q_push;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_not_empty;
  logic                      back_stall;
  logic [EW-1:0]             front_entry;
  logic [EW-1:0]             q_head;
  logic [3:0][WORD_BITS-1:0] res;

  // component order w, x, y, z on the packed buses
  assign in_a = {in_a_z, in_a_y, in_a_x, in_a_w};
  assign in_b = {in_b_z, in_b_y, in_b_x, in_b_w};

  // front end: registers the request and zeroes b's scalar for rotation
  qmr_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_a     (in_a),
    .in_b     (in_b),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_entry  (front_entry)
  );

  // queue between the two halves so the front does not see output stalls until it fills
  qmr_fifo #(
    .DW (EW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_head)
  );

  assign q_pop = q_not_empty && !back_stall;

  // back end: product pipeline, second pass for rotation, output register
  qmr_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_stall      (back_stall),
    .q_entry      (q_head),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_r        (res),
    .out_overflow (out_overflow)
  );

  assign out_r_w = res[0];
  assign out_r_x = res[1];
  assign out_r_y = res[2];
  assign out_r_z = res[3];

endmodule
